// ===== hw/rtl/pra_pkg.sv =====
// Shared types and constants of the page range allocator.
`timescale 1ns / 1ps
package pra_pkg;

   localparam int DEF_RANGE_SLOTS      = 64;
   localparam int DEF_PAGE_NUMBER_BITS = 52;
   localparam int FIELD_BITS           = 52;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_RESERVE = 2'd1;
   localparam logic [1:0] CMD_FREE    = 2'd2;
   localparam logic [1:0] CMD_BAD     = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOFIT   = 3'd1;
   localparam logic [2:0] ST_ZERO    = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_OVERLAP = 3'd4;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [FIELD_BITS-1:0] start_page;
      logic [FIELD_BITS-1:0] page_count;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [FIELD_BITS-1:0] result_page;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_WAIT,
      S_UPDATE,
      S_SPLIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic best_found;
      logic holder_found;
      logic lo_found;
      logic hi_found;
      logic spare_found;
      logic overlap;
   } scan_flags_type;

endpackage

// ===== hw/rtl/pra_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module pra_ram #(
   parameter int WIDTH = 104,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pra_scan.sv =====
// Scan unit: compares one table entry per cycle while step is high and keeps the candidates.
`timescale 1ns / 1ps
module pra_scan #(
   parameter int RANGE_SLOTS      = pra_pkg::DEF_RANGE_SLOTS,
   parameter int PAGE_NUMBER_BITS = pra_pkg::DEF_PAGE_NUMBER_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic                           step,
   input  logic [$clog2(RANGE_SLOTS)-1:0] idx,
   input  logic                           slot_used,
   input  logic [PAGE_NUMBER_BITS-1:0]    ent_first,
   input  logic [PAGE_NUMBER_BITS-1:0]    ent_len,
   input  logic [PAGE_NUMBER_BITS-1:0]    start,
   input  logic [PAGE_NUMBER_BITS-1:0]    count,
   input  logic [PAGE_NUMBER_BITS:0]      span_end,
   output pra_pkg::scan_flags_type        flags,
   output logic [$clog2(RANGE_SLOTS)-1:0] best_idx,
   output logic [PAGE_NUMBER_BITS-1:0]    best_first,
   output logic [PAGE_NUMBER_BITS-1:0]    best_len,
   output logic [$clog2(RANGE_SLOTS)-1:0] holder_idx,
   output logic [PAGE_NUMBER_BITS-1:0]    holder_first,
   output logic [PAGE_NUMBER_BITS:0]      holder_end,
   output logic [$clog2(RANGE_SLOTS)-1:0] lo_idx,
   output logic [PAGE_NUMBER_BITS-1:0]    lo_first,
   output logic [PAGE_NUMBER_BITS-1:0]    lo_len,
   output logic [$clog2(RANGE_SLOTS)-1:0] hi_idx,
   output logic [PAGE_NUMBER_BITS-1:0]    hi_len,
   output logic [$clog2(RANGE_SLOTS)-1:0] spare_idx
);

   localparam int IW = $clog2(RANGE_SLOTS);
   localparam int W  = PAGE_NUMBER_BITS;

   pra_pkg::scan_flags_type flags_ff, flags_in;
   logic [IW-1:0] best_idx_ff, best_idx_in, holder_idx_ff, holder_idx_in;
   logic [IW-1:0] lo_idx_ff, lo_idx_in, hi_idx_ff, hi_idx_in, spare_idx_ff, spare_idx_in;
   logic [W-1:0]  best_first_ff, best_first_in, best_len_ff, best_len_in;
   logic [W-1:0]  holder_first_ff, holder_first_in;
   logic [W:0]    holder_end_ff, holder_end_in;
   logic [W-1:0]  lo_first_ff, lo_first_in, lo_len_ff, lo_len_in;
   logic [W-1:0]  hi_len_ff, hi_len_in;
   logic [W:0]    ent_end;
   logic [W:0]    ent_first_x;

   assign ent_first_x = {1'b0, ent_first};
   assign ent_end     = ent_first_x + {1'b0, ent_len};

   always_comb begin
      flags_in        = flags_ff;
      best_idx_in     = best_idx_ff;
      best_first_in   = best_first_ff;
      best_len_in     = best_len_ff;
      holder_idx_in   = holder_idx_ff;
      holder_first_in = holder_first_ff;
      holder_end_in   = holder_end_ff;
      lo_idx_in       = lo_idx_ff;
      lo_first_in     = lo_first_ff;
      lo_len_in       = lo_len_ff;
      hi_idx_in       = hi_idx_ff;
      hi_len_in       = hi_len_ff;
      spare_idx_in    = spare_idx_ff;
      if (clear) begin
         flags_in = '0;
      end else if (step) begin
         if (!slot_used) begin
            if (!flags_ff.spare_found) begin
               flags_in.spare_found = 1'b1;
               spare_idx_in         = idx;
            end
         end else begin
            // best fit, ties to the lowest first page
            if (ent_len >= count && (!flags_ff.best_found || ent_len < best_len_ff ||
                (ent_len == best_len_ff && ent_first < best_first_ff))) begin
               flags_in.best_found = 1'b1;
               best_idx_in         = idx;
               best_first_in       = ent_first;
               best_len_in         = ent_len;
            end
            if (!flags_ff.holder_found && ent_first <= start && ent_end >= span_end) begin
               flags_in.holder_found = 1'b1;
               holder_idx_in         = idx;
               holder_first_in       = ent_first;
               holder_end_in         = ent_end;
            end
            if (ent_first_x < span_end && ent_end > {1'b0, start}) begin
               flags_in.overlap = 1'b1;
            end
            if (ent_end == {1'b0, start}) begin
               flags_in.lo_found = 1'b1;
               lo_idx_in         = idx;
               lo_first_in       = ent_first;
               lo_len_in         = ent_len;
            end
            if (ent_first_x == span_end) begin
               flags_in.hi_found = 1'b1;
               hi_idx_in         = idx;
               hi_len_in         = ent_len;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff     <= best_idx_in;
      best_first_ff   <= best_first_in;
      best_len_ff     <= best_len_in;
      holder_idx_ff   <= holder_idx_in;
      holder_first_ff <= holder_first_in;
      holder_end_ff   <= holder_end_in;
      lo_idx_ff       <= lo_idx_in;
      lo_first_ff     <= lo_first_in;
      lo_len_ff       <= lo_len_in;
      hi_idx_ff       <= hi_idx_in;
      hi_len_ff       <= hi_len_in;
      spare_idx_ff    <= spare_idx_in;
   end

   assign flags        = flags_ff;
   assign best_idx     = best_idx_ff;
   assign best_first   = best_first_ff;
   assign best_len     = best_len_ff;
   assign holder_idx   = holder_idx_ff;
   assign holder_first = holder_first_ff;
   assign holder_end   = holder_end_ff;
   assign lo_idx       = lo_idx_ff;
   assign lo_first     = lo_first_ff;
   assign lo_len       = lo_len_ff;
   assign hi_idx       = hi_idx_ff;
   assign hi_len       = hi_len_ff;
   assign spare_idx    = spare_idx_ff;

endmodule

// ===== hw/rtl/page_range_allocator_top.sv =====
// Top level of the page range allocator: sequencer, slot table and result register.
//
//   port group   dir  word          handshake
//   req_         in   req_type      req_valid / req_stall
//   rsp_         out  rsp_type      rsp_valid / rsp_stall
//
// A command that scans walks the whole slot table through its single read port; a reserve that
// splits a range also passes through S_SPLIT to write the second half.
// A bad command, a zero count or a free past the page space skips the scan and answers from S_DONE.
// Reset empties the table at once by clearing the per-slot in-use bits.
// The next word is taken while a finished result still waits under rsp_stall.
`timescale 1ns / 1ps
module page_range_allocator_top #(
   parameter int RANGE_SLOTS      = pra_pkg::DEF_RANGE_SLOTS,
   parameter int PAGE_NUMBER_BITS = pra_pkg::DEF_PAGE_NUMBER_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pra_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pra_pkg::rsp_type rsp_word
);

   localparam int IW = $clog2(RANGE_SLOTS);
   localparam int W  = PAGE_NUMBER_BITS;
   localparam logic [IW-1:0] LAST_SLOT = IW'(RANGE_SLOTS - 1);

   pra_pkg::state_type state_ff, state_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic [W-1:0]           start_ff, start_in, count_ff, count_in;
   logic [W:0]             end_ff, end_in;
   logic [IW-1:0]          idx_ff, idx_in, proc_idx_ff, proc_idx_in;
   logic                   proc_ff, proc_in;
   logic [RANGE_SLOTS-1:0] used_ff, used_in;
   logic [2:0]             stat_ff, stat_in;
   logic [W-1:0]           page_ff, page_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pra_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   accept, clear;
   logic [W-1:0]           req_start, req_count;
   logic [W:0]             req_end;
   logic                   wr_en;
   logic [IW-1:0]          wr_addr;
   logic [2*W-1:0]         wr_data, rd_data;

   pra_pkg::scan_flags_type flags;
   logic [IW-1:0] best_idx, holder_idx, lo_idx, hi_idx, spare_idx;
   logic [W-1:0]  best_first, best_len, holder_first, lo_first, lo_len, hi_len;
   logic [W:0]    holder_end;
   logic [W-1:0]  before_len, after_len;
   logic          bef_nz, aft_nz;

   assign req_stall = (state_ff != pra_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_start = req_word.start_page[W-1:0];
   assign req_count = req_word.page_count[W-1:0];
   assign req_end   = {1'b0, req_start} + {1'b0, req_count};

   assign before_len = start_ff - holder_first;
   assign after_len  = W'(holder_end - end_ff);
   assign bef_nz     = (start_ff != holder_first);
   assign aft_nz     = (holder_end != end_ff);

   pra_ram #(
      .WIDTH(2 * W),
      .DEPTH(RANGE_SLOTS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   pra_scan #(
      .RANGE_SLOTS     (RANGE_SLOTS),
      .PAGE_NUMBER_BITS(PAGE_NUMBER_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (clear),
      .step        (proc_ff),
      .idx         (proc_idx_ff),
      .slot_used   (used_ff[proc_idx_ff]),
      .ent_first   (rd_data[2*W-1:W]),
      .ent_len     (rd_data[W-1:0]),
      .start       (start_ff),
      .count       (count_ff),
      .span_end    (end_ff),
      .flags       (flags),
      .best_idx    (best_idx),
      .best_first  (best_first),
      .best_len    (best_len),
      .holder_idx  (holder_idx),
      .holder_first(holder_first),
      .holder_end  (holder_end),
      .lo_idx      (lo_idx),
      .lo_first    (lo_first),
      .lo_len      (lo_len),
      .hi_idx      (hi_idx),
      .hi_len      (hi_len),
      .spare_idx   (spare_idx)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      end_in       = end_ff;
      idx_in       = idx_ff;
      proc_in      = 1'b0;
      proc_idx_in  = idx_ff;
      used_in      = used_ff;
      stat_in      = stat_ff;
      page_in      = page_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      clear        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = best_idx;
      wr_data      = '0;
      unique case (state_ff)
         pra_pkg::S_IDLE: begin
            if (accept) begin
               cmd_in   = req_word.cmd;
               start_in = req_start;
               count_in = req_count;
               end_in   = req_end;
               idx_in   = '0;
               page_in  = '0;
               clear    = 1'b1;
               state_in = pra_pkg::S_DONE;
               if (req_word.cmd == pra_pkg::CMD_BAD) begin
                  stat_in = pra_pkg::ST_NOFIT;
               end else if (req_count == '0) begin
                  stat_in = pra_pkg::ST_ZERO;
               end else if (req_word.cmd == pra_pkg::CMD_FREE && req_end[W]) begin
                  stat_in = pra_pkg::ST_NOFIT;
               end else begin
                  state_in = pra_pkg::S_SCAN;
               end
            end
         end
         pra_pkg::S_SCAN: begin
            proc_in = 1'b1;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == LAST_SLOT) begin
               state_in = pra_pkg::S_WAIT;
            end
         end
         pra_pkg::S_WAIT: begin
            state_in = pra_pkg::S_UPDATE;
         end
         pra_pkg::S_UPDATE: begin
            state_in = pra_pkg::S_DONE;
            stat_in  = pra_pkg::ST_OK;
            case (cmd_ff)
               pra_pkg::CMD_ALLOC: begin
                  if (!flags.best_found) begin
                     stat_in = pra_pkg::ST_NOFIT;
                  end else begin
                     page_in = best_first;
                     if (best_len == count_ff) begin
                        used_in[best_idx] = 1'b0;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = best_idx;
                        wr_data = {best_first + count_ff, best_len - count_ff};
                     end
                  end
               end
               pra_pkg::CMD_RESERVE: begin
                  wr_addr = holder_idx;
                  if (!flags.holder_found) begin
                     stat_in = pra_pkg::ST_NOFIT;
                  end else if (bef_nz && aft_nz) begin
                     if (!flags.spare_found) begin
                        stat_in = pra_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_data  = {holder_first, before_len};
                        state_in = pra_pkg::S_SPLIT;
                     end
                  end else if (bef_nz) begin
                     wr_en   = 1'b1;
                     wr_data = {holder_first, before_len};
                  end else if (aft_nz) begin
                     wr_en   = 1'b1;
                     wr_data = {end_ff[W-1:0], after_len};
                  end else begin
                     used_in[holder_idx] = 1'b0;
                  end
               end
               default: begin
                  if (flags.overlap) begin
                     stat_in = pra_pkg::ST_OVERLAP;
                  end else if (flags.lo_found) begin
                     wr_en   = 1'b1;
                     wr_addr = lo_idx;
                     wr_data = {lo_first, lo_len + count_ff + (flags.hi_found ? hi_len : '0)};
                     if (flags.hi_found) begin
                        used_in[hi_idx] = 1'b0;
                     end
                  end else if (flags.hi_found) begin
                     wr_en   = 1'b1;
                     wr_addr = hi_idx;
                     wr_data = {start_ff, hi_len + count_ff};
                  end else if (!flags.spare_found) begin
                     stat_in = pra_pkg::ST_FULL;
                  end else begin
                     wr_en              = 1'b1;
                     wr_addr            = spare_idx;
                     wr_data            = {start_ff, count_ff};
                     used_in[spare_idx] = 1'b1;
                  end
               end
            endcase
         end
         pra_pkg::S_SPLIT: begin
            // second half of a split reserve goes to the lowest free slot
            wr_en              = 1'b1;
            wr_addr            = spare_idx;
            wr_data            = {end_ff[W-1:0], after_len};
            used_in[spare_idx] = 1'b1;
            state_in           = pra_pkg::S_DONE;
         end
         pra_pkg::S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = stat_ff;
               rsp_in.result_page = (stat_ff == pra_pkg::ST_OK) ?
                                    pra_pkg::FIELD_BITS'(page_ff) : '0;
               state_in           = pra_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pra_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pra_pkg::S_IDLE;
         used_ff      <= '0;
         proc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         proc_ff      <= proc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      start_ff    <= start_in;
      count_ff    <= count_in;
      end_ff      <= end_in;
      idx_ff      <= idx_in;
      proc_idx_ff <= proc_idx_in;
      stat_ff     <= stat_in;
      page_ff     <= page_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pra_pkg::S_SCAN || state_ff == pra_pkg::S_WAIT) |-> !wr_en)
      else $error("table written during scan");

   a_split_has_spare: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pra_pkg::S_SPLIT) |-> flags.spare_found)
      else $error("split without a free slot");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pra_pkg::S_DONE && state_in == pra_pkg::S_IDLE) |=> rsp_valid_ff)
      else $error("result lost on completion");

   a_step_only_scanning: assert property (@(posedge clock) disable iff (reset)
      proc_ff |-> (state_ff == pra_pkg::S_SCAN || state_ff == pra_pkg::S_WAIT))
      else $error("scan step outside scan");

endmodule

// ===== sim/testbench.sv =====
// Testbench for the page range allocator: random and directed commands checked against a model.
`timescale 1ns / 1ps
module testbench;

   localparam int SLOTS = 64;
   localparam logic [51:0] PAGE_TOP = {52{1'b1}};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pra_pkg::req_type req_word = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pra_pkg::rsp_type rsp_word;

   page_range_allocator_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // free-range table mirror
   logic [51:0] span_first [SLOTS];
   logic [51:0] span_len   [SLOTS];
   logic        span_live  [SLOTS];

   pra_pkg::req_type pending_words[$];
   pra_pkg::rsp_type expected_rsps[$];
   int      fail_count = 0;
   int      hold_cycles = 0;
   bit      hold_req = 1'b0;
   bit      hold_taken = 1'b0;
   logic    req_taken = 1'b0;

   function automatic int lowest_empty_slot();
      for (int i = 0; i < SLOTS; i++)
         if (!span_live[i]) return i;
      return -1;
   endfunction

   function automatic pra_pkg::rsp_type allocator_step(pra_pkg::req_type w);
      pra_pkg::rsp_type r;
      int best, holder, spare, lo, hi;
      logic [51:0] s, c, e, f, fe, lead, after;
      r = '0;
      s = w.start_page;
      c = w.page_count;
      e = s + c;
      best = -1; holder = -1; lo = -1; hi = -1;
      if (w.cmd == pra_pkg::CMD_BAD) r.status = pra_pkg::ST_NOFIT;
      else if (c == 0) r.status = pra_pkg::ST_ZERO;
      else if (w.cmd == pra_pkg::CMD_ALLOC) begin
         for (int i = 0; i < SLOTS; i++)
            if (span_live[i] && span_len[i] >= c)
               if (best < 0 || span_len[i] < span_len[best] ||
                   (span_len[i] == span_len[best] && span_first[i] < span_first[best]))
                  best = i;
         if (best < 0) r.status = pra_pkg::ST_NOFIT;
         else begin
            r.status = pra_pkg::ST_OK;
            r.result_page = span_first[best];
            if (span_len[best] == c) span_live[best] = 1'b0;
            else begin
               span_first[best] += c;
               span_len[best] -= c;
            end
         end
      end else if (w.cmd == pra_pkg::CMD_RESERVE) begin
         for (int i = 0; i < SLOTS; i++)
            if (holder < 0 && span_live[i] && span_first[i] <= s &&
                {1'b0, span_first[i]} + span_len[i] >= {1'b0, s} + c)
               holder = i;
         if (holder < 0) r.status = pra_pkg::ST_NOFIT;
         else begin
            fe = span_first[holder] + span_len[holder];
            lead = s - span_first[holder];
            after = fe - e;
            r.status = pra_pkg::ST_OK;
            if (lead != 0 && after != 0) begin
               spare = lowest_empty_slot();
               if (spare < 0) r.status = pra_pkg::ST_FULL;
               else begin
                  span_len[holder] = lead;
                  span_first[spare] = e;
                  span_len[spare] = after;
                  span_live[spare] = 1'b1;
               end
            end else if (lead != 0) span_len[holder] = lead;
            else if (after != 0) begin
               span_first[holder] = e;
               span_len[holder] = after;
            end else span_live[holder] = 1'b0;
         end
      end else begin
         if ({1'b0, s} + c > {1'b0, PAGE_TOP}) r.status = pra_pkg::ST_NOFIT;
         else begin
            r.status = pra_pkg::ST_OK;
            for (int i = 0; i < SLOTS; i++)
               if (span_live[i]) begin
                  f = span_first[i];
                  fe = f + span_len[i];
                  if (f < e && fe > s) r.status = pra_pkg::ST_OVERLAP;
                  if (fe == s) lo = i;
                  if (f == e) hi = i;
               end
            if (r.status == pra_pkg::ST_OK) begin
               if (lo >= 0) begin
                  span_len[lo] += c;
                  if (hi >= 0) begin
                     span_len[lo] += span_len[hi];
                     span_live[hi] = 1'b0;
                  end
               end else if (hi >= 0) begin
                  span_first[hi] = s;
                  span_len[hi] += c;
               end else begin
                  spare = lowest_empty_slot();
                  if (spare < 0) r.status = pra_pkg::ST_FULL;
                  else begin
                     span_first[spare] = s;
                     span_len[spare] = c;
                     span_live[spare] = 1'b1;
                  end
               end
            end
         end
      end
      return r;
   endfunction

   function automatic pra_pkg::req_type make_word(logic [1:0] cmd, logic [51:0] s,
                                                  logic [51:0] c);
      pra_pkg::req_type w;
      w.cmd = cmd;
      w.start_page = s;
      w.page_count = c;
      return w;
   endfunction

   function automatic logic [51:0] rand52();
      logic [63:0] v;
      v = {$urandom, $urandom} >> $urandom_range(0, 12);
      return v[51:0];
   endfunction

   // sender: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
               end else burst_left <= burst_left - 1;
            end else req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall)
         expected_rsps.push_back(allocator_step(req_word));
   end

   // receiver: own stall pattern plus one long hold-off
   int rx_phase = 0;
   always @(negedge clock) begin
      rx_phase <= rx_phase + 1;
      if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_cycles <= 3000;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (rx_phase % 2000 < 700) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < 40);
   end

   // checker
   always @(posedge clock) begin
      pra_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result word %h", rsp_word);
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_word.status);
               fail_count++;
            end
            if (rsp_word.result_page !== want.result_page) begin
               $error("result_page: expected %h, got %h",
                      want.result_page, rsp_word.result_page);
               fail_count++;
            end
         end
      end
   end

   initial begin
      logic [51:0] b;
      logic [1:0] op;
      for (int i = 0; i < SLOTS; i++) span_live[i] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed: empty table, zero count, bad command, extremes, split, coalesce
      pending_words.push_back(make_word(pra_pkg::CMD_ALLOC, 52'd0, 52'd1));
      pending_words.push_back(make_word(pra_pkg::CMD_RESERVE, 52'd5, 52'd1));
      pending_words.push_back(make_word(pra_pkg::CMD_FREE, 52'd0, 52'd0));
      pending_words.push_back(make_word(pra_pkg::CMD_BAD, PAGE_TOP, PAGE_TOP));
      pending_words.push_back(make_word(pra_pkg::CMD_FREE, PAGE_TOP, 52'd1));
      pending_words.push_back(make_word(pra_pkg::CMD_FREE, 52'd0, PAGE_TOP));
      pending_words.push_back(make_word(pra_pkg::CMD_FREE, 52'd100, 52'd50));
      pending_words.push_back(make_word(pra_pkg::CMD_FREE, 52'd120, 52'd5));
      pending_words.push_back(make_word(pra_pkg::CMD_FREE, 52'd200, 52'd10));
      pending_words.push_back(make_word(pra_pkg::CMD_FREE, 52'd150, 52'd50));
      pending_words.push_back(make_word(pra_pkg::CMD_FREE, 52'd300, 52'd10));
      pending_words.push_back(make_word(pra_pkg::CMD_ALLOC, 52'd0, 52'd10));
      pending_words.push_back(make_word(pra_pkg::CMD_ALLOC, 52'd0, 52'd110));
      pending_words.push_back(make_word(pra_pkg::CMD_RESERVE, 52'd120, 52'd1));
      pending_words.push_back(make_word(pra_pkg::CMD_RESERVE, 52'd130, 52'd10));
      pending_words.push_back(make_word(pra_pkg::CMD_RESERVE, 52'd190, 52'd20));
      pending_words.push_back(make_word(pra_pkg::CMD_ALLOC, 52'd0, PAGE_TOP));
      pending_words.push_back(make_word(pra_pkg::CMD_FREE, PAGE_TOP - 52'd1, 52'd1));
      // fill the table with isolated spans, then full-table cases
      for (int i = 0; i < SLOTS + 2; i++)
         pending_words.push_back(make_word(pra_pkg::CMD_FREE, 52'(1000 + 4 * i), 52'd2));
      pending_words.push_back(make_word(pra_pkg::CMD_RESERVE, 52'(1000 + 4 * 70), 52'd1));
      pending_words.push_back(make_word(pra_pkg::CMD_RESERVE, 52'd1000, 52'd1));
      for (int i = 0; i < 40; i++)
         pending_words.push_back(make_word(pra_pkg::CMD_ALLOC, 52'd0, 52'd2));
      // random: small page window so commands interact
      for (int i = 0; i < 480; i++) begin
         op = 2'($urandom_range(0, 2));
         if ($urandom_range(0, 30) == 0) op = pra_pkg::CMD_BAD;
         if ($urandom_range(0, 25) == 0)
            pending_words.push_back(make_word(op, rand52(), rand52()));
         else begin
            b = 52'($urandom_range(0, 4000));
            pending_words.push_back(make_word(op, b, 52'($urandom_range(0, 40))));
         end
         if (i == 240) begin
            wait (pending_words.size() < 250);
            hold_req = 1'b1;
         end
      end
      wait (pending_words.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/pra_pkg.sv
hw/rtl/pra_ram.sv
hw/rtl/pra_scan.sv
hw/rtl/page_range_allocator_top.sv
sim/testbench.sv
